// ===== hdl/cfp_pkg.sv =====
// Shared types, codes and limit tables of the command frame parser.
`default_nettype none
package cfp_pkg;

  // Module ids below this are eligible; the limit table has one row for each of them.
  localparam int NUM_MODULES = 18;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = NUM_MODULES;
  localparam int OUT_DATA_W  = 48;
  localparam int OUT_USER_W  = 4;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MODULE_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_ANY    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP_TIMEOUT   = 2'd2;

  localparam logic [NUM_MODULES-1:0] MODULE_ENABLE_RST = 18'd1;
  localparam logic [15:0]            GAP_TIMEOUT_RST   = 16'd2000;

  // input item kind
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [7:0] END_BYTE   = 8'h00;

  // result status codes
  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_HEADER   = 3'd1;
  localparam logic [2:0] ST_ARG      = 3'd2;
  localparam logic [2:0] ST_COMPLETE = 3'd3;
  localparam logic [2:0] ST_DROPPED  = 3'd4;

  typedef struct packed {
    logic [7:0] max_function;
    logic [7:0] max_count;
    logic [7:0] max_length;
  } limits_t;

  function automatic limits_t limits_of(input logic [7:0] id);
    limits_t l;
    case (id)
      8'd0:    l = '{8'd3, 8'd1,   8'd5};
      8'd1:    l = '{8'd3, 8'd1,   8'd2};
      8'd2:    l = '{8'd2, 8'd255, 8'd255};
      8'd3:    l = '{8'd3, 8'd1,   8'd32};
      8'd4:    l = '{8'd9, 8'd3,   8'd4};
      8'd5:    l = '{8'd4, 8'd1,   8'd2};
      8'd6:    l = '{8'd2, 8'd1,   8'd1};
      8'd7:    l = '{8'd0, 8'd0,   8'd0};
      8'd8:    l = '{8'd2, 8'd2,   8'd4};
      8'd9:    l = '{8'd3, 8'd1,   8'd2};
      8'd10:   l = '{8'd3, 8'd1,   8'd1};
      8'd11:   l = '{8'd4, 8'd26,  8'd3};
      8'd12:   l = '{8'd6, 8'd2,   8'd50};
      8'd13:   l = '{8'd5, 8'd1,   8'd255};
      8'd14:   l = '{8'd3, 8'd1,   8'd1};
      8'd15:   l = '{8'd1, 8'd2,   8'd1};
      8'd16:   l = '{8'd1, 8'd1,   8'd2};
      8'd17:   l = '{8'd3, 8'd100, 8'd255};
      default: l = '{8'd0, 8'd0,   8'd0};
    endcase
    return l;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cfp_limits.sv =====
// Per-module limit lookup and module id acceptance check.
`default_nettype none
module cfp_limits (
  input  logic [7:0]                     module_sel,
  input  logic [7:0]                     candidate,
  input  logic [cfp_pkg::NUM_MODULES-1:0] module_enable,
  input  logic                           accept_any_module,
  output cfp_pkg::limits_t               limits,
  output logic                           candidate_ok
);
  import cfp_pkg::*;

  logic        in_range;
  logic        enable_bit;
  logic [31:0] enable_wide;

  assign limits      = limits_of(module_sel);
  assign in_range    = ({24'd0, candidate} < NUM_MODULES);
  // ids 18 to 31 read a zero enable bit; larger ids wrap, and the range check rejects them
  assign enable_wide = 32'(module_enable);
  assign enable_bit  = enable_wide[candidate[4:0]];
  // id 0 is always registered
  assign candidate_ok = in_range &&
                        ((candidate == 8'd0) || accept_any_module || enable_bit);

endmodule
`default_nettype wire

// ===== hdl/command_frame_parser_core.sv =====
// Top level of the command frame parser: byte/tick stream in, per-byte status out.
// Each input transfer is either a received byte or a one-millisecond tick. Every byte is
// decoded in the cycle it is accepted and its status transfer is offered from the next cycle;
// ticks only advance the inter-byte gap counter and yield nothing. One item is accepted per
// clock; the only limit is the single output register, so a stalled master side holds the
// input until the pending status is taken. Configuration writes are accepted every cycle and
// should be issued only while the parser is idle.
`default_nettype none
module command_frame_parser_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // rx_byte
  input  logic                           s_axis_tuser,  // op
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // module, function, arg_count, arg_index, byte_index, arg_byte
  output logic [cfp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status[2:0], timed_out[3]
  output logic [cfp_pkg::OUT_USER_W-1:0] m_axis_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cfp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cfp_pkg::*;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_MODULE   = 3'd1;
  localparam logic [2:0] PH_FUNCTION = 3'd2;
  localparam logic [2:0] PH_COUNT    = 3'd3;
  localparam logic [2:0] PH_LENGTH   = 3'd4;
  localparam logic [2:0] PH_DATA     = 3'd5;
  localparam logic [2:0] PH_END      = 3'd6;

  // configuration
  logic [NUM_MODULES-1:0] module_enable;
  logic                   accept_any_module;
  logic [15:0]            gap_timeout_ms;

  // parser state
  logic       in_frame,       in_frame_next;
  logic [2:0] phase,          phase_next;
  logic [7:0] cur_module,     cur_module_next;
  logic [7:0] cur_function,   cur_function_next;
  logic [7:0] cur_arg_count,  cur_arg_count_next;
  logic [7:0] cur_arg_index,  cur_arg_index_next;
  logic [7:0] cur_arg_length, cur_arg_length_next;
  logic [7:0] cur_byte_index, cur_byte_index_next;
  logic [15:0] idle_ticks,    idle_ticks_next;

  // result register
  logic       out_valid;
  logic [2:0] out_status,     out_status_next;
  logic       out_timed_out,  out_timed_out_next;
  logic [7:0] out_module;
  logic [7:0] out_function;
  logic [7:0] out_arg_count;
  logic [7:0] out_arg_index,  out_arg_index_next;
  logic [7:0] out_byte_index, out_byte_index_next;
  logic [7:0] out_arg_byte,   out_arg_byte_next;

  logic    in_accept;
  logic    byte_accept;
  logic    timeout;
  limits_t limits;
  logic    candidate_ok;
  logic [7:0] rx_byte;

  assign rx_byte       = s_axis_tdata;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign byte_accept   = in_accept && (s_axis_tuser == OP_BYTE);
  assign cfg_ready     = 1'b1;

  cfp_limits u_limits (
    .module_sel        (cur_module),
    .candidate         (rx_byte),
    .module_enable     (module_enable),
    .accept_any_module (accept_any_module),
    .limits            (limits),
    .candidate_ok      (candidate_ok)
  );

  assign timeout = in_frame && (idle_ticks > gap_timeout_ms);

  always_comb begin
    in_frame_next       = in_frame;
    phase_next          = phase;
    cur_module_next     = cur_module;
    cur_function_next   = cur_function;
    cur_arg_count_next  = cur_arg_count;
    cur_arg_index_next  = cur_arg_index;
    cur_arg_length_next = cur_arg_length;
    cur_byte_index_next = cur_byte_index;
    idle_ticks_next     = idle_ticks;
    out_status_next     = ST_NONE;
    out_timed_out_next  = 1'b0;
    out_arg_index_next  = 8'd0;
    out_byte_index_next = 8'd0;
    out_arg_byte_next   = 8'd0;

    if (s_axis_tuser == OP_TICK) begin
      if (idle_ticks != 16'hFFFF) begin
        idle_ticks_next = idle_ticks + 16'd1;
      end
    end else begin
      idle_ticks_next = 16'd0;
      // a stale frame is closed first, then the byte is seen as outside a frame
      if (timeout) begin
        in_frame_next      = 1'b0;
        phase_next         = PH_IDLE;
        out_timed_out_next = 1'b1;
      end
      if (!in_frame || timeout) begin
        if (rx_byte == START_BYTE) begin
          in_frame_next      = 1'b1;
          phase_next         = PH_MODULE;
          cur_module_next    = 8'd0;
          cur_function_next  = 8'd0;
          cur_arg_count_next = 8'd0;
          out_status_next    = ST_HEADER;
        end
      end else begin
        case (phase)
          PH_MODULE: begin
            cur_module_next = rx_byte;
            if (candidate_ok) begin
              phase_next      = PH_FUNCTION;
              out_status_next = ST_HEADER;
            end else begin
              in_frame_next   = 1'b0;
              phase_next      = PH_IDLE;
              out_status_next = ST_DROPPED;
            end
          end
          PH_FUNCTION: begin
            cur_function_next = rx_byte;
            if (rx_byte > limits.max_function) begin
              in_frame_next   = 1'b0;
              phase_next      = PH_IDLE;
              out_status_next = ST_DROPPED;
            end else begin
              phase_next      = PH_COUNT;
              out_status_next = ST_HEADER;
            end
          end
          PH_COUNT: begin
            cur_arg_count_next  = rx_byte;
            cur_arg_index_next  = 8'd0;
            cur_byte_index_next = 8'd0;
            if (rx_byte > limits.max_count) begin
              in_frame_next   = 1'b0;
              phase_next      = PH_IDLE;
              out_status_next = ST_DROPPED;
            end else begin
              phase_next      = PH_LENGTH;
              out_status_next = ST_HEADER;
            end
          end
          PH_LENGTH: begin
            cur_byte_index_next = 8'd0;
            cur_arg_length_next = rx_byte;
            if (rx_byte > limits.max_length) begin
              in_frame_next   = 1'b0;
              phase_next      = PH_IDLE;
              out_status_next = ST_DROPPED;
            end else begin
              phase_next      = (cur_arg_count != 8'd0) ? PH_DATA : PH_END;
              out_status_next = ST_HEADER;
            end
          end
          PH_DATA: begin
            // a zero-length argument swallows one byte without storing it
            if (cur_byte_index < cur_arg_length) begin
              out_status_next     = ST_ARG;
              out_arg_index_next  = cur_arg_index;
              out_byte_index_next = cur_byte_index;
              out_arg_byte_next   = rx_byte;
              cur_byte_index_next = cur_byte_index + 8'd1;
            end else begin
              out_status_next = ST_HEADER;
            end
            if (cur_byte_index_next == cur_arg_length) begin
              phase_next         = PH_LENGTH;
              cur_arg_index_next = cur_arg_index + 8'd1;
            end
            if (cur_arg_index_next == cur_arg_count) begin
              phase_next = PH_END;
            end
          end
          PH_END: begin
            in_frame_next   = 1'b0;
            phase_next      = PH_IDLE;
            out_status_next = (rx_byte == END_BYTE) ? ST_COMPLETE : ST_DROPPED;
          end
          default: begin
            in_frame_next   = 1'b0;
            phase_next      = PH_IDLE;
            out_status_next = ST_DROPPED;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      module_enable     <= MODULE_ENABLE_RST;
      accept_any_module <= 1'b0;
      gap_timeout_ms    <= GAP_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODULE_ENABLE: module_enable     <= cfg_data;
        REG_ACCEPT_ANY:    accept_any_module <= cfg_data[0];
        REG_GAP_TIMEOUT:   gap_timeout_ms    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      phase          <= PH_IDLE;
      cur_module     <= 8'd0;
      cur_function   <= 8'd0;
      cur_arg_count  <= 8'd0;
      cur_arg_index  <= 8'd0;
      cur_arg_length <= 8'd0;
      cur_byte_index <= 8'd0;
      idle_ticks     <= 16'd0;
      out_valid      <= 1'b0;
    end else begin
      if (in_accept) begin
        in_frame       <= in_frame_next;
        phase          <= phase_next;
        cur_module     <= cur_module_next;
        cur_function   <= cur_function_next;
        cur_arg_count  <= cur_arg_count_next;
        cur_arg_index  <= cur_arg_index_next;
        cur_arg_length <= cur_arg_length_next;
        cur_byte_index <= cur_byte_index_next;
        idle_ticks     <= idle_ticks_next;
      end
      if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (byte_accept) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept) begin
      out_status     <= out_status_next;
      out_timed_out  <= out_timed_out_next;
      out_module     <= cur_module_next;
      out_function   <= cur_function_next;
      out_arg_count  <= cur_arg_count_next;
      out_arg_index  <= out_arg_index_next;
      out_byte_index <= out_byte_index_next;
      out_arg_byte   <= out_arg_byte_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_arg_byte, out_byte_index, out_arg_index,
                          out_arg_count, out_function, out_module};
  assign m_axis_tuser  = {out_timed_out, out_status};

  // a fresh result only follows an accepted byte
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_BYTE)))
    else $error("result without an accepted byte");

  assert property (@(posedge clk) disable iff (rst)
    in_frame == (phase != PH_IDLE))
    else $error("frame flag and phase disagree");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (out_status == ST_ARG)) |-> (out_byte_index < cur_arg_length))
    else $error("argument byte beyond argument length");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_timed_out) |-> ((out_status == ST_NONE) || (out_status == ST_HEADER)))
    else $error("timed-out byte not handled as outside a frame");

endmodule
`default_nettype wire
